// File: rtl/catmull_rom_segment_eval_assert.svh
// ============================================================================
// Catmull-Rom segment evaluator assertion macros
// Shorthand for concurrent checks clocked on aclk.
// ============================================================================
`ifndef CATMULL_ROM_SEGMENT_EVAL_ASSERT_SVH
`define CATMULL_ROM_SEGMENT_EVAL_ASSERT_SVH

// Check that is suspended while aresetn is low.
`define CRSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also runs during reset.
`define CRSE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/crse_pkg.sv
// ============================================================================
// crse_pkg
// Shared types and fixed constants of the Catmull-Rom segment evaluator.
// ============================================================================
`default_nettype none

package crse_pkg;

    localparam int AXIS_W = 2;
    typedef logic [AXIS_W-1:0] axis_t;

    // Headroom of the doubled basis weights above Q.F (magnitude < 5.0).
    localparam int WEIGHT_GUARD = 3;

    // Growth of the four-term dot product over a single product.
    localparam int SUM_GUARD = 2;

    // Number of control points per segment.
    localparam int NUM_POINTS = 4;

endpackage

`default_nettype wire

// File: rtl/crse_basis.sv
// ============================================================================
// crse_basis
// Three pipeline stages: t^2, t^3 and the four doubled basis weights.
// ============================================================================
`default_nettype none

module crse_basis #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [FRAC_BITS:0]                            in_t,
    input  logic [crse_pkg::NUM_POINTS-1:0][COORD_WIDTH-1:0] in_points,
    input  crse_pkg::axis_t                               in_axis,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [crse_pkg::NUM_POINTS-1:0][FRAC_BITS+crse_pkg::WEIGHT_GUARD:0] out_weights,
    output logic [crse_pkg::NUM_POINTS-1:0][COORD_WIDTH-1:0] out_points,
    output crse_pkg::axis_t                               out_axis
);

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = 2 * TW;
    localparam int WW = FRAC_BITS + crse_pkg::WEIGHT_GUARD + 1;
    localparam int NP = crse_pkg::NUM_POINTS;

    localparam logic [TW-1:0]        ONE_Q  = TW'(1) << FRAC_BITS;
    localparam logic [PW-1:0]        HALF_Q = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [WW-1:0] TWO_Q  = WW'(1) << (FRAC_BITS + 1);

    // stage A: clamp, t*t
    logic                          a_valid_reg;
    logic                          a_ready;
    logic [TW-1:0]                 a_t_reg;
    logic [PW-1:0]                 a_tt_reg;
    logic [PW-1:0]                 a_tt_next;
    logic [TW-1:0]                 t_clamp;
    logic [NP-1:0][COORD_WIDTH-1:0] a_pts_reg;
    crse_pkg::axis_t               a_axis_reg;

    // stage B: round t^2, t2*t
    logic                          b_valid_reg;
    logic                          b_ready;
    logic [TW-1:0]                 b_t_reg;
    logic [TW-1:0]                 b_t2_reg;
    logic [PW-1:0]                 b_t3p_reg;
    logic [TW-1:0]                 b_t2_next;
    logic [PW-1:0]                 b_t3p_next;
    logic [PW-1:0]                 b_t2_sum;
    logic [NP-1:0][COORD_WIDTH-1:0] b_pts_reg;
    crse_pkg::axis_t               b_axis_reg;

    // stage C: round t^3, weights
    logic                          c_valid_reg;
    logic                          c_ready;
    logic [PW-1:0]                 c_t3_sum;
    logic signed [WW-1:0]          ts;
    logic signed [WW-1:0]          t2s;
    logic signed [WW-1:0]          t3s;
    logic [NP-1:0][WW-1:0]         c_w_reg;
    logic [NP-1:0][WW-1:0]         c_w_next;
    logic [NP-1:0][COORD_WIDTH-1:0] c_pts_reg;
    crse_pkg::axis_t               c_axis_reg;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign c_ready  = !c_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_comb begin
        t_clamp    = (in_t > ONE_Q) ? ONE_Q : in_t;
        a_tt_next  = PW'(t_clamp) * PW'(t_clamp);

        b_t2_sum   = a_tt_reg + HALF_Q;
        b_t2_next  = b_t2_sum[FRAC_BITS +: TW];
        b_t3p_next = PW'(b_t2_next) * PW'(a_t_reg);

        c_t3_sum   = b_t3p_reg + HALF_Q;
        ts  = $signed({{(WW-TW){1'b0}}, b_t_reg});
        t2s = $signed({{(WW-TW){1'b0}}, b_t2_reg});
        t3s = $signed({{(WW-TW){1'b0}}, c_t3_sum[FRAC_BITS +: TW]});

        c_w_next[0] = -t3s + (t2s <<< 1) - ts;
        c_w_next[1] = (t3s <<< 1) + t3s - ((t2s <<< 2) + t2s) + TWO_Q;
        c_w_next[2] = -((t3s <<< 1) + t3s) + (t2s <<< 2) + ts;
        c_w_next[3] = t3s - t2s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_t_reg    <= t_clamp;
            a_tt_reg   <= a_tt_next;
            a_pts_reg  <= in_points;
            a_axis_reg <= in_axis;
        end
        if (b_ready && a_valid_reg) begin
            b_t_reg    <= a_t_reg;
            b_t2_reg   <= b_t2_next;
            b_t3p_reg  <= b_t3p_next;
            b_pts_reg  <= a_pts_reg;
            b_axis_reg <= a_axis_reg;
        end
        if (c_ready && b_valid_reg) begin
            c_w_reg    <= c_w_next;
            c_pts_reg  <= b_pts_reg;
            c_axis_reg <= b_axis_reg;
        end
    end

    assign out_valid   = c_valid_reg;
    assign out_weights = c_w_reg;
    assign out_points  = c_pts_reg;
    assign out_axis    = c_axis_reg;

endmodule

`default_nettype wire

// File: rtl/crse_mac.sv
// ============================================================================
// crse_mac
// Two pipeline stages: four point-by-weight products, then their sum
// plus the rounding bias.
// ============================================================================
`default_nettype none

module crse_mac #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [crse_pkg::NUM_POINTS-1:0][FRAC_BITS+crse_pkg::WEIGHT_GUARD:0] in_weights,
    input  logic [crse_pkg::NUM_POINTS-1:0][COORD_WIDTH-1:0] in_points,
    input  crse_pkg::axis_t                               in_axis,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [COORD_WIDTH+FRAC_BITS+crse_pkg::WEIGHT_GUARD+crse_pkg::SUM_GUARD:0] out_sum,
    output crse_pkg::axis_t                               out_axis
);

    localparam int WW = FRAC_BITS + crse_pkg::WEIGHT_GUARD + 1;
    localparam int PW = COORD_WIDTH + WW;
    localparam int SW = PW + crse_pkg::SUM_GUARD;
    localparam int NP = crse_pkg::NUM_POINTS;

    // bias for halving with round-half-up: 2^F
    localparam logic signed [SW-1:0] RND = SW'(1) << FRAC_BITS;

    logic                  d_valid_reg;
    logic                  d_ready;
    logic [NP-1:0][PW-1:0] d_prod_reg;
    logic [NP-1:0][PW-1:0] d_prod_next;
    crse_pkg::axis_t       d_axis_reg;

    logic                  e_valid_reg;
    logic                  e_ready;
    logic signed [SW-1:0]  e_sum_reg;
    logic signed [SW-1:0]  e_sum_next;
    crse_pkg::axis_t       e_axis_reg;

    assign d_ready  = !d_valid_reg || e_ready;
    assign e_ready  = !e_valid_reg || out_ready;
    assign in_ready = d_ready;

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            d_prod_next[i] = PW'($signed(in_points[i])) * PW'($signed(in_weights[i]));
        end
        e_sum_next = SW'($signed(d_prod_reg[0])) + SW'($signed(d_prod_reg[1]))
                   + SW'($signed(d_prod_reg[2])) + SW'($signed(d_prod_reg[3])) + RND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= in_valid;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && in_valid) begin
            d_prod_reg <= d_prod_next;
            d_axis_reg <= in_axis;
        end
        if (e_ready && d_valid_reg) begin
            e_sum_reg  <= e_sum_next;
            e_axis_reg <= d_axis_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_sum   = e_sum_reg;
    assign out_axis  = e_axis_reg;

endmodule

`default_nettype wire

// File: rtl/crse_round.sv
// ============================================================================
// crse_round
// Output stage: halve and round, saturate, hold the result word.
// ============================================================================
`default_nettype none

module crse_round #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [COORD_WIDTH+FRAC_BITS+crse_pkg::WEIGHT_GUARD+crse_pkg::SUM_GUARD:0] in_sum,
    input  crse_pkg::axis_t             in_axis,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [COORD_WIDTH:0] out_value,
    output crse_pkg::axis_t             out_axis
);

    localparam int SW = COORD_WIDTH + FRAC_BITS + crse_pkg::WEIGHT_GUARD
                      + crse_pkg::SUM_GUARD + 1;
    localparam int OW = COORD_WIDTH + 1;

    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << COORD_WIDTH) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) << COORD_WIDTH);

    logic                 f_valid_reg;
    logic signed [OW-1:0] f_value_reg;
    logic signed [OW-1:0] f_value_next;
    crse_pkg::axis_t      f_axis_reg;
    logic signed [SW-1:0] shifted;

    assign in_ready = !f_valid_reg || out_ready;

    always_comb begin
        shifted = $signed(in_sum) >>> (FRAC_BITS + 1);
        priority if (shifted > SAT_HI) begin
            f_value_next = SAT_HI[OW-1:0];
        end else if (shifted < SAT_LO) begin
            f_value_next = SAT_LO[OW-1:0];
        end else begin
            f_value_next = shifted[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (in_ready) begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            f_value_reg <= f_value_next;
            f_axis_reg  <= in_axis;
        end
    end

    assign out_valid = f_valid_reg;
    assign out_value = f_value_reg;
    assign out_axis  = f_axis_reg;

endmodule

`default_nettype wire

// File: rtl/catmull_rom_segment_eval.sv
// ============================================================================
// catmull_rom_segment_eval
// One axis of a uniform Catmull-Rom cubic segment per word, fully pipelined.
// ============================================================================
//
//  channel | ports                                       | dir | word
//  --------+---------------------------------------------+-----+-----------------
//  s_      | s_valid s_ready s_param_t s_point_0..3      | in  | t, 4 points, axis
//          | s_axis_tag                                  |     |
//  m_      | m_valid m_ready m_curve_value m_axis_out    | out | value, axis
//
//  Throughput: one word per cycle while m_ready is high. An accepted word is
//  loaded into the first of six register stages (t^2, t^3, weights,
//  products, sum, round/saturate) and moves on through each in order.
//  Reset: synchronous, active low aresetn; clears the stage valid bits only.
//  Stalls: each stage holds while its successor is full and stalled, so
//  s_ready drops only when all six stages hold words and m_ready is low.
// ============================================================================
`default_nettype none

`include "catmull_rom_segment_eval_assert.svh"

module catmull_rom_segment_eval #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [FRAC_BITS:0]            s_param_t,
    input  logic signed [COORD_WIDTH-1:0] s_point_0,
    input  logic signed [COORD_WIDTH-1:0] s_point_1,
    input  logic signed [COORD_WIDTH-1:0] s_point_2,
    input  logic signed [COORD_WIDTH-1:0] s_point_3,
    input  crse_pkg::axis_t               s_axis_tag,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH:0]   m_curve_value,
    output crse_pkg::axis_t               m_axis_out
);

    localparam int NP = crse_pkg::NUM_POINTS;
    localparam int WW = FRAC_BITS + crse_pkg::WEIGHT_GUARD + 1;
    localparam int SW = COORD_WIDTH + WW + crse_pkg::SUM_GUARD;

    logic [NP-1:0][COORD_WIDTH-1:0] in_points;

    // basis -> mac
    logic                           bm_valid;
    logic                           bm_ready;
    logic [NP-1:0][WW-1:0]          bm_weights;
    logic [NP-1:0][COORD_WIDTH-1:0] bm_points;
    crse_pkg::axis_t                bm_axis;

    // mac -> round
    logic                           mr_valid;
    logic                           mr_ready;
    logic [SW-1:0]                  mr_sum;
    crse_pkg::axis_t                mr_axis;

    // index i carries point_i
    assign in_points = {s_point_3, s_point_2, s_point_1, s_point_0};

    // stages 1-3: clamp t, t^2, t^3 (rounded Q.F), doubled weights
    crse_basis #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_basis (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_t        (s_param_t),
        .in_points   (in_points),
        .in_axis     (s_axis_tag),
        .out_valid   (bm_valid),
        .out_ready   (bm_ready),
        .out_weights (bm_weights),
        .out_points  (bm_points),
        .out_axis    (bm_axis)
    );

    // stages 4-5: p_i * W_i, then the exact sum plus 2^F
    crse_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (bm_valid),
        .in_ready    (bm_ready),
        .in_weights  (bm_weights),
        .in_points   (bm_points),
        .in_axis     (bm_axis),
        .out_valid   (mr_valid),
        .out_ready   (mr_ready),
        .out_sum     (mr_sum),
        .out_axis    (mr_axis)
    );

    // stage 6: arithmetic shift by F+1 (halve + round half up), saturate
    crse_round #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_round (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mr_valid),
        .in_ready    (mr_ready),
        .in_sum      (mr_sum),
        .in_axis     (mr_axis),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_value   (m_curve_value),
        .out_axis    (m_axis_out)
    );

    // ---- checks ----
    // a reset cycle leaves no result word pending
    `CRSE_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result word valid after reset")
    // the input can only be refused when the output is full and stalled
    `CRSE_ASSERT(a_stall_source, !s_ready |-> (m_valid && !m_ready), "s_ready low without output stall")
    // inner hops refuse only under a downstream stall as well
    `CRSE_ASSERT(a_inner_ready, !mr_ready |-> (m_valid && !m_ready), "round stage stalled without output stall")

endmodule

`default_nettype wire

// File: dv/catmull_rom_segment_eval_tb.sv
// ============================================================================
// catmull_rom_segment_eval_tb
// Self-checking bench for the Catmull-Rom segment evaluator. A queue of
// point words (directed corners, then random 3-D points issued one axis per
// word) feeds a falling-edge driver. A rising-edge monitor predicts every
// accepted word and checks each result word in order against that prediction.
// ============================================================================
`default_nettype none

module catmull_rom_segment_eval_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W  = 16;
    localparam int FRAC     = 16;
    localparam int LATENCY  = 6;
    // cycles with no handshake on either side before the run is declared hung
    localparam int HANG_LIMIT = 4000;

    localparam longint ONE_Q  = longint'(1) << FRAC;
    localparam longint HALF_Q = longint'(1) << (FRAC - 1);
    localparam longint VAL_HI = (longint'(1) << COORD_W) - 1;
    localparam longint VAL_LO = -(longint'(1) << COORD_W);

    localparam logic [FRAC:0] T_ZERO = '0;
    localparam logic [FRAC:0] T_ONE  = 17'(ONE_Q);
    localparam logic [FRAC:0] T_MAX  = '1;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam crse_pkg::axis_t AX_X   = 2'd0;
    localparam crse_pkg::axis_t AX_Y   = 2'd1;
    localparam crse_pkg::axis_t AX_Z   = 2'd2;
    localparam crse_pkg::axis_t AX_BAD = 2'd3;

    typedef struct {
        logic [FRAC:0]               t;
        logic signed [COORD_W-1:0]   p [crse_pkg::NUM_POINTS];
        crse_pkg::axis_t             axis;
    } point_word_t;

    typedef struct {
        logic signed [COORD_W:0] value;
        crse_pkg::axis_t         axis;
    } curve_word_t;

    // ------------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------------
    logic aclk;
    logic aresetn = 1'b0;

    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [FRAC:0]               s_param_t = '0;
    logic signed [COORD_W-1:0]   s_point_0 = '0;
    logic signed [COORD_W-1:0]   s_point_1 = '0;
    logic signed [COORD_W-1:0]   s_point_2 = '0;
    logic signed [COORD_W-1:0]   s_point_3 = '0;
    crse_pkg::axis_t             s_axis_tag = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [COORD_W:0]     m_curve_value;
    crse_pkg::axis_t             m_axis_out;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    catmull_rom_segment_eval #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_param_t     (s_param_t),
        .s_point_0     (s_point_0),
        .s_point_1     (s_point_1),
        .s_point_2     (s_point_2),
        .s_point_3     (s_point_3),
        .s_axis_tag    (s_axis_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_curve_value (m_curve_value),
        .m_axis_out    (m_axis_out)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    point_word_t point_word_q [$];     // words waiting for the driver
    curve_word_t pending_curve_q [$];  // predicted results, oldest first

    int  send_idle_pct  = 0;           // chance per cycle the sender holds off
    int  recv_stall_pct = 0;           // chance per cycle m_ready is low
    logic word_taken    = 1'b0;        // s_ handshake at the last rising edge

    int mismatch_count = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int over_range_t   = 0;
    int hang_cycles    = 0;

    // ------------------------------------------------------------------------
    // predictor: doubled basis weights in Q.F, exact dot product, then
    // halve + round half up, saturate to COORD_W+1 signed bits
    // ------------------------------------------------------------------------
    function automatic logic signed [COORD_W:0] catmull_value(
        input logic [FRAC:0]             t_raw,
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2,
        input logic signed [COORD_W-1:0] p3
    );
        longint t, t2, t3;
        longint w0, w1, w2, w3;
        longint acc, r;
        t  = (longint'(t_raw) > ONE_Q) ? ONE_Q : longint'(t_raw);
        t2 = (t * t + HALF_Q) >>> FRAC;
        t3 = (t2 * t + HALF_Q) >>> FRAC;
        w0 = -t3 + 2 * t2 - t;
        w1 = 3 * t3 - 5 * t2 + 2 * ONE_Q;
        w2 = -3 * t3 + 4 * t2 + t;
        w3 = t3 - t2;
        acc = longint'(p0) * w0 + longint'(p1) * w1
            + longint'(p2) * w2 + longint'(p3) * w3;
        r = (acc + ONE_Q) >>> (FRAC + 1);
        if (r > VAL_HI) r = VAL_HI;
        if (r < VAL_LO) r = VAL_LO;
        return r[COORD_W:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t ns] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic push_word(
        input logic [FRAC:0]             t,
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2,
        input logic signed [COORD_W-1:0] p3,
        input crse_pkg::axis_t           axis
    );
        point_word_t w;
        w.t    = t;
        w.p[0] = p0;
        w.p[1] = p1;
        w.p[2] = p2;
        w.p[3] = p3;
        w.axis = axis;
        point_word_q.push_back(w);
    endtask

    // coordinates lean on the rails now and then
    function automatic logic signed [COORD_W-1:0] rand_coord();
        unique case ($urandom_range(0, 9))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return COORD_W'($urandom_range(0, 15)) - COORD_W'(8);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // mostly inside [0, 1.0], with ends and out-of-range values mixed in
    function automatic logic [FRAC:0] rand_param();
        unique case ($urandom_range(0, 19))
            0:       return T_ZERO;
            1:       return T_ONE;
            2:       return 17'($urandom_range(32'(ONE_Q + 1), 32'(2 * ONE_Q - 1)));
            3:       return 17'($urandom_range(0, 3));
            default: return 17'($urandom_range(0, 32'(ONE_Q)));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: updates on the falling edge, holds a word until it is taken
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        point_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || word_taken) begin
                if (point_word_q.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    w = point_word_q.pop_front();
                    s_valid    <= 1'b1;
                    s_param_t  <= w.t;
                    s_point_0  <= w.p[0];
                    s_point_1  <= w.p[1];
                    s_point_2  <= w.p[2];
                    s_point_3  <= w.p[3];
                    s_axis_tag <= w.axis;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples on the rising edge, predicts accepted input words,
    // checks result words in order, and watches for a hang
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        curve_word_t exp_w;
        curve_word_t got_w;
        logic        m_fire;
        if (aresetn) begin
            word_taken = s_valid && s_ready;
            m_fire     = m_valid && m_ready;

            if (word_taken) begin
                exp_w.value = catmull_value(s_param_t, s_point_0, s_point_1,
                                            s_point_2, s_point_3);
                exp_w.axis  = s_axis_tag;
                pending_curve_q.push_back(exp_w);
                words_sent++;
                if (s_param_t > T_ONE) over_range_t++;
            end

            if (m_fire) begin
                got_w.value = m_curve_value;
                got_w.axis  = m_axis_out;
                if (pending_curve_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing pending: value %0d axis %0d",
                                              got_w.value, got_w.axis));
                end else begin
                    exp_w = pending_curve_q.pop_front();
                    if (got_w.value !== exp_w.value)
                        report_mismatch($sformatf("curve_value got %0d expected %0d",
                                                  got_w.value, exp_w.value));
                    if (got_w.axis !== exp_w.axis)
                        report_mismatch($sformatf("axis_out got %0d expected %0d",
                                                  got_w.axis, exp_w.axis));
                    words_checked++;
                end
            end

            // hang watch: any handshake on either side resets the count
            if (word_taken || m_fire) hang_cycles = 0;
            else                      hang_cycles++;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d results pending",
                         hang_cycles, pending_curve_q.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end else begin
            word_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus sequencer
    // ------------------------------------------------------------------------
    // idle mixes per random phase: free-running, sender gaps, receiver
    // stalls, then light gaps on both sides
    int phase_send [4] = '{0, 46, 0, 8};
    int phase_recv [4] = '{0, 0, 46, 8};

    initial begin
        logic [FRAC:0]   t;
        crse_pkg::axis_t ax;
        int              tail;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed corners, no idling ----
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // t = 0 lands on point_1, t = 1.0 on point_2
        push_word(T_ZERO, C_MAX, C_MIN, C_MAX, C_MIN, AX_X);
        push_word(T_ZERO, C_MIN, C_MAX, C_MIN, C_MAX, AX_Y);
        push_word(T_ONE,  C_MAX, C_MIN, C_MAX, C_MIN, AX_Z);
        push_word(T_ONE,  C_MIN, C_MAX, C_MIN, C_MAX, AX_X);
        // t above one clamps to 1.0, including all ones
        push_word(T_ONE + 17'd1, 16'sd100, -16'sd200, 16'sd300, -16'sd400, AX_Y);
        push_word(T_MAX,  C_MIN, C_MAX, C_MIN, C_MAX, AX_Z);
        push_word(T_MAX,  C_MAX, C_MAX, C_MAX, C_MAX, AX_BAD);
        // largest overshoot around mid-segment
        push_word(17'(HALF_Q), C_MIN, C_MAX, C_MAX, C_MIN, AX_X);
        push_word(17'(HALF_Q), C_MAX, C_MIN, C_MIN, C_MAX, AX_Y);
        push_word(17'd21845,   C_MIN, C_MAX, C_MAX, C_MIN, AX_Z);
        push_word(17'd43691,   C_MAX, C_MIN, C_MIN, C_MAX, AX_X);
        // flat rails and zero
        push_word(17'd12345, C_MAX, C_MAX, C_MAX, C_MAX, AX_Y);
        push_word(17'd54321, C_MIN, C_MIN, C_MIN, C_MIN, AX_Z);
        push_word(T_MAX,     16'sd0, 16'sd0, 16'sd0, 16'sd0, AX_BAD);
        // smallest and largest steps in t
        push_word(17'd1,             C_MIN, C_MAX, C_MIN, C_MAX, AX_X);
        push_word(T_ONE - 17'd1,     C_MIN, C_MAX, C_MIN, C_MAX, AX_Y);
        push_word(17'd1,             -16'sd1, 16'sd1, -16'sd1, 16'sd1, AX_Z);
        push_word(T_ONE - 17'd1,     16'sd1, -16'sd1, 16'sd1, -16'sd1, AX_BAD);
        // rounding near half steps, the first on a straight line
        push_word(17'(HALF_Q), -16'sd1, 16'sd0, 16'sd1, 16'sd2, AX_X);
        push_word(17'(HALF_Q), 16'sd0, 16'sd0, 16'sd1, 16'sd1, AX_Y);
        push_word(17'd16384,   16'sd3, -16'sd3, 16'sd3, -16'sd3, AX_Z);
        push_word(17'd49152,   -16'sd3, 16'sd3, -16'sd3, 16'sd3, AX_X);

        // sender holds until every pending result is back
        while (point_word_q.size() > 0 || s_valid || pending_curve_q.size() > 0)
            @(posedge aclk);

        // ---- random 3-D points, one axis per word ----
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int n = 0; n < 160; n++) begin
                t = rand_param();
                if ($urandom_range(0, 15) == 0) begin
                    // stray word: random tag, unrelated t
                    ax = crse_pkg::axis_t'($urandom_range(0, 3));
                    push_word(rand_param(), rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), ax);
                end
                push_word(t, rand_coord(), rand_coord(), rand_coord(), rand_coord(), AX_X);
                push_word(t, rand_coord(), rand_coord(), rand_coord(), rand_coord(), AX_Y);
                push_word(t, rand_coord(), rand_coord(), rand_coord(), rand_coord(), AX_Z);
            end
            while (point_word_q.size() > 0 || s_valid || pending_curve_q.size() > 0)
                @(posedge aclk);
        end

        // let any stray result drain out of the pipe
        recv_stall_pct = 0;
        tail = LATENCY * 4;
        repeat (tail) @(posedge aclk);

        if (pending_curve_q.size() > 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_curve_q.size()));

        $display("covered %0d input words (%0d with t above one) over four idle mixes;",
                 words_sent, over_range_t);
        $display("checked %0d result words, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
